### design/s5h_pkg.sv
// Shared types, codes and result-expansion functions for the SOCKS5 handshake block.
`default_nettype none

package s5h_pkg;

  // Pending-transaction queue between the parser and the output register
  localparam int unsigned QDepth = 8;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  // Protocol bytes
  localparam logic [7:0] SOCKS_VER   = 8'h05;
  localparam logic [7:0] CMD_CONNECT = 8'h01;
  localparam logic [7:0] RSV_BYTE    = 8'h00;
  localparam logic [7:0] REP_OK      = 8'h00;
  localparam logic [7:0] REP_FAIL    = 8'h01;
  localparam logic [7:0] ATYP_IPV4   = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN = 8'h03;
  localparam logic [7:0] IPV4_LEN    = 8'd4;

  // Result kinds
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_NAME   = 2'd2;

  // Outcome codes
  localparam logic [2:0] OC_ACCEPTED     = 3'd0;
  localparam logic [2:0] OC_BAD_GREET    = 3'd1;
  localparam logic [2:0] OC_BAD_REQ_VER  = 3'd2;
  localparam logic [2:0] OC_BAD_CMD      = 3'd3;
  localparam logic [2:0] OC_BAD_RSV      = 3'd4;
  localparam logic [2:0] OC_BAD_ATYP     = 3'd5;

  // One queued entry stands for every result that one client byte causes
  typedef enum logic [2:0] {
    BND_FAIL_QUIET,  // outcome report only
    BND_FAIL_REPLY,  // 05 01, outcome report
    BND_GREET_OK,    // 05 00
    BND_ATYP_OK,     // 05 00 00 type
    BND_ECHO,        // echo of the byte
    BND_NAME,        // echo, then name byte
    BND_PORT_LO      // echo, then accepted report
  } bundle_e;

  typedef struct packed {
    bundle_e     code;
    logic [7:0]  data;
    logic [2:0]  outcome;
    logic [1:0]  atyp;
    logic [31:0] addr;
    logic [15:0] port;
  } bundle_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [2:0]  outcome;
    logic [1:0]  address_type;
    logic [31:0] ipv4_address;
    logic [15:0] dest_port;
    logic        last;
  } result_t;

  // Index of the final result of an entry
  function automatic logic [1:0] bundle_last_idx(bundle_e code);
    logic [1:0] n;
    case (code)
      BND_FAIL_QUIET: n = 2'd0;
      BND_FAIL_REPLY: n = 2'd2;
      BND_GREET_OK:   n = 2'd1;
      BND_ATYP_OK:    n = 2'd3;
      BND_ECHO:       n = 2'd0;
      BND_NAME:       n = 2'd1;
      BND_PORT_LO:    n = 2'd1;
      default:        n = 2'd0;
    endcase
    return n;
  endfunction

  // Expand result number idx of an entry
  function automatic result_t bundle_result(bundle_t b, logic [1:0] idx);
    result_t r;
    r = '0;
    r.kind = KIND_TX;
    case (b.code)
      BND_FAIL_QUIET: begin
        r.kind    = KIND_REPORT;
        r.outcome = b.outcome;
      end
      BND_FAIL_REPLY: begin
        case (idx)
          2'd0:    r.tx_byte = SOCKS_VER;
          2'd1:    r.tx_byte = REP_FAIL;
          default: begin
            r.kind    = KIND_REPORT;
            r.outcome = b.outcome;
          end
        endcase
      end
      BND_GREET_OK: begin
        r.tx_byte = (idx == 2'd0) ? SOCKS_VER : REP_OK;
      end
      BND_ATYP_OK: begin
        case (idx)
          2'd0:    r.tx_byte = SOCKS_VER;
          2'd1:    r.tx_byte = REP_OK;
          2'd2:    r.tx_byte = RSV_BYTE;
          default: r.tx_byte = b.data;
        endcase
      end
      BND_ECHO: begin
        r.tx_byte = b.data;
      end
      BND_NAME: begin
        r.tx_byte = b.data;
        if (idx != 2'd0) begin
          r.kind = KIND_NAME;
        end
      end
      BND_PORT_LO: begin
        if (idx == 2'd0) begin
          r.tx_byte = b.data;
        end else begin
          r.kind         = KIND_REPORT;
          r.outcome      = OC_ACCEPTED;
          r.address_type = b.atyp;
          r.ipv4_address = b.addr;
          r.dest_port    = b.port;
        end
      end
      default: r = '0;
    endcase
    r.last = (idx == bundle_last_idx(b.code));
    return r;
  endfunction

endpackage

`default_nettype wire

### design/socks5_connect_handshake.sv
// Top level of the SOCKS5 no-auth CONNECT server handshake.
//
// Takes one client byte per transaction on the input channel (cmd_i high
// starts a new connection and gives no results) and one result per
// transaction on the output channel: reply bytes for the client, domain name
// bytes and a final outcome report carrying the address type, IPv4 address
// and port. A byte is accepted in every cycle while in_stall_o is low. The
// parser works on the byte in the cycle it is accepted and files every
// result that byte causes (up to four) as one entry in an eight-entry queue;
// the output register then hands results out one per cycle while
// out_stall_i is low, and with the queue empty a result still passes
// through the queue and the output register before it appears. in_stall_o
// rises only when the queue is full: either the sink stalls while bytes with
// results keep arriving, or a run of bytes that each give more than one
// result (domain name bytes give two) outpaces the output.
`default_nettype none

module socks5_connect_handshake (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // client byte channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        cmd_i,
  input  wire logic [7:0]  rx_byte_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       tx_byte_o,
  output logic [2:0]       outcome_o,
  output logic [1:0]       address_type_o,
  output logic [31:0]      ipv4_address_o,
  output logic [15:0]      dest_port_o,
  output logic             last_o
);
  import s5h_pkg::*;

  logic       accept;
  logic       push;
  bundle_t    push_bundle;
  logic       q_full;
  logic       head_valid;
  bundle_t    head;
  result_t    head_res;
  logic       load;
  logic       pop;
  logic [1:0] idx_q;
  logic       out_valid_q;
  result_t    out_q;

  // Accept a byte whenever the queue has room
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !in_stall_o;

  s5h_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .cmd_i     (cmd_i),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .bundle_o  (push_bundle)
  );

  s5h_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .bundle_i     (push_bundle),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Expand the head entry one result at a time; idx_q walks through it
  assign head_res = bundle_result(head, idx_q);

  // Load the output register when it is empty or its transaction completes
  assign load = head_valid && (!out_valid_q || !out_stall_i);
  // Drop the head entry once its final result is loaded
  assign pop  = load && head_res.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= head_res.last ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= head_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign tx_byte_o      = out_q.tx_byte;
  assign outcome_o      = out_q.outcome;
  assign address_type_o = out_q.address_type;
  assign ipv4_address_o = out_q.ipv4_address;
  assign dest_port_o    = out_q.dest_port;
  assign last_o         = out_q.last;

endmodule

`default_nettype wire

### design/s5h_parse.sv
// Handshake parser: phase tracking and per-byte result entry generation.
`default_nettype none

module s5h_parse (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic             cmd_i,
  input  wire logic [7:0]       rx_byte_i,
  output logic                  push_o,
  output s5h_pkg::bundle_t      bundle_o
);
  import s5h_pkg::*;

  typedef enum logic [3:0] {
    PH_GREET_VER, PH_GREET_CNT, PH_METHODS, PH_REQ_VER, PH_REQ_CMD,
    PH_REQ_RSV, PH_REQ_ATYP, PH_IPV4, PH_DLEN, PH_NAME, PH_PORT_HI,
    PH_PORT_LO, PH_DONE, PH_ERROR
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  left_q, left_d;
  logic [1:0]  type_q, type_d;
  logic [31:0] addr_q, addr_d;
  logic [7:0]  port_hi_q, port_hi_d;
  logic [7:0]  left_dec;
  logic [7:0]  b;

  assign b        = rx_byte_i;
  assign left_dec = left_q - 8'd1;

  always_comb begin
    phase_d   = phase_q;
    left_d    = left_q;
    type_d    = type_q;
    addr_d    = addr_q;
    port_hi_d = port_hi_q;
    push_o    = 1'b0;
    bundle_o  = '0;
    bundle_o.data = b;

    if (accept_i && cmd_i) begin
      // new connection: back to greeting
      phase_d   = PH_GREET_VER;
      left_d    = '0;
      type_d    = '0;
      addr_d    = '0;
      port_hi_d = '0;
    end else if (accept_i) begin
      case (phase_q)
        PH_GREET_VER: begin
          if (b != SOCKS_VER) begin
            push_o           = 1'b1;
            bundle_o.code    = BND_FAIL_QUIET;
            bundle_o.outcome = OC_BAD_GREET;
            phase_d          = PH_ERROR;
          end else begin
            phase_d = PH_GREET_CNT;
          end
        end
        PH_GREET_CNT: begin
          left_d = b;
          if (b == 8'd0) begin
            push_o        = 1'b1;
            bundle_o.code = BND_GREET_OK;
            phase_d       = PH_REQ_VER;
          end else begin
            phase_d = PH_METHODS;
          end
        end
        PH_METHODS: begin
          left_d = left_dec;
          if (left_dec == 8'd0) begin
            push_o        = 1'b1;
            bundle_o.code = BND_GREET_OK;
            phase_d       = PH_REQ_VER;
          end
        end
        PH_REQ_VER, PH_REQ_CMD, PH_REQ_RSV: begin
          if (phase_q == PH_REQ_VER && b != SOCKS_VER) begin
            push_o           = 1'b1;
            bundle_o.code    = BND_FAIL_REPLY;
            bundle_o.outcome = OC_BAD_REQ_VER;
            phase_d          = PH_ERROR;
          end else if (phase_q == PH_REQ_CMD && b != CMD_CONNECT) begin
            push_o           = 1'b1;
            bundle_o.code    = BND_FAIL_REPLY;
            bundle_o.outcome = OC_BAD_CMD;
            phase_d          = PH_ERROR;
          end else if (phase_q == PH_REQ_RSV && b != RSV_BYTE) begin
            push_o           = 1'b1;
            bundle_o.code    = BND_FAIL_REPLY;
            bundle_o.outcome = OC_BAD_RSV;
            phase_d          = PH_ERROR;
          end else begin
            phase_d = phase_e'(phase_q + 4'd1);
          end
        end
        PH_REQ_ATYP: begin
          push_o = 1'b1;
          if (b == ATYP_IPV4 || b == ATYP_DOMAIN) begin
            bundle_o.code = BND_ATYP_OK;
            type_d        = b[1:0];
            addr_d        = '0;
            if (b == ATYP_IPV4) begin
              left_d  = IPV4_LEN;
              phase_d = PH_IPV4;
            end else begin
              phase_d = PH_DLEN;
            end
          end else begin
            bundle_o.code    = BND_FAIL_REPLY;
            bundle_o.outcome = OC_BAD_ATYP;
            phase_d          = PH_ERROR;
          end
        end
        PH_IPV4: begin
          push_o        = 1'b1;
          bundle_o.code = BND_ECHO;
          addr_d        = {addr_q[23:0], b};
          left_d        = left_dec;
          if (left_dec == 8'd0) begin
            phase_d = PH_PORT_HI;
          end
        end
        PH_DLEN: begin
          push_o        = 1'b1;
          bundle_o.code = BND_ECHO;
          left_d        = b;
          phase_d       = (b == 8'd0) ? PH_PORT_HI : PH_NAME;
        end
        PH_NAME: begin
          push_o        = 1'b1;
          bundle_o.code = BND_NAME;
          left_d        = left_dec;
          if (left_dec == 8'd0) begin
            phase_d = PH_PORT_HI;
          end
        end
        PH_PORT_HI: begin
          push_o        = 1'b1;
          bundle_o.code = BND_ECHO;
          port_hi_d     = b;
          phase_d       = PH_PORT_LO;
        end
        PH_PORT_LO: begin
          push_o        = 1'b1;
          bundle_o.code = BND_PORT_LO;
          bundle_o.atyp = type_q;
          bundle_o.addr = (type_q == ATYP_IPV4[1:0]) ? addr_q : '0;
          bundle_o.port = {port_hi_q, b};
          phase_d       = PH_DONE;
        end
        default: begin
          // finished, failed or unreachable: drop the byte
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_GREET_VER;
      left_q    <= '0;
      type_q    <= '0;
      addr_q    <= '0;
      port_hi_q <= '0;
    end else begin
      phase_q   <= phase_d;
      left_q    <= left_d;
      type_q    <= type_d;
      addr_q    <= addr_d;
      port_hi_q <= port_hi_d;
    end
  end

endmodule

`default_nettype wire

### design/s5h_fifo.sv
// Queue of pending result entries between the parser and the output register.
`default_nettype none

module s5h_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire s5h_pkg::bundle_t  bundle_i,
  input  wire logic              pop_i,
  output logic                   full_o,
  output logic                   head_valid_o,
  output s5h_pkg::bundle_t       head_o
);
  import s5h_pkg::*;

  bundle_t        mem_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCw-1:0] count_q;
  logic           do_push, do_pop;

  assign full_o       = (count_q == QCw'(QDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  function automatic logic [QAw-1:0] ptr_next(logic [QAw-1:0] p);
    return (p == QAw'(QDepth - 1)) ? '0 : p + QAw'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCw'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCw'(1);
      end
    end
  end

endmodule

`default_nettype wire

### design/s5h_checker.sv
// Port-level checks on the SOCKS5 handshake block, bound to its top level.
`default_nettype none

module s5h_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        out_valid_o,
  input  wire logic        out_stall_i,
  input  wire logic [1:0]  kind_o,
  input  wire logic [7:0]  tx_byte_o,
  input  wire logic [2:0]  outcome_o,
  input  wire logic [1:0]  address_type_o,
  input  wire logic [31:0] ipv4_address_o,
  input  wire logic [15:0] dest_port_o,
  input  wire logic        last_o
);
  import s5h_pkg::*;

  // A stalled result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(tx_byte_o) && $stable(outcome_o) && $stable(last_o))
    else $error("stalled result changed");

  // An outcome report always closes its transaction group
  a_report_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_REPORT |-> last_o)
    else $error("outcome report not marked last");

  // A freshly shown name byte follows its echo and closes the group
  a_name_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_NAME && !$past(out_valid_o && out_stall_i) |->
      last_o && $past(out_valid_o) && $past(kind_o) == KIND_TX &&
      $past(tx_byte_o) == tx_byte_o)
    else $error("name byte without matching echo");

  // Only reports carry outcome and destination fields
  a_plain_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_REPORT |-> outcome_o == 3'd0 &&
      address_type_o == 2'd0 && ipv4_address_o == 32'd0 && dest_port_o == 16'd0)
    else $error("destination fields set on a byte result");

endmodule

bind socks5_connect_handshake s5h_checker u_s5h_checker (.*);

`default_nettype wire

### sim/s5h_handshake_checker.sv
`timescale 1ns / 100ps
// Checker for the SOCKS5 handshake: predicts each accepted byte's results and compares them.
module s5h_handshake_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              cmd_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [1:0]        kind_i,
  input  logic [7:0]        tx_byte_i,
  input  logic [2:0]        outcome_i,
  input  logic [1:0]        address_type_i,
  input  logic [31:0]       ipv4_address_i,
  input  logic [15:0]       dest_port_i,
  input  logic              last_i,
  output int unsigned       error_count_o,
  output int unsigned       pending_count_o
);
  import s5h_pkg::*;

  typedef enum logic [3:0] {
    HS_GREET_VER, HS_GREET_CNT, HS_METHODS, HS_REQ_VER, HS_REQ_CMD, HS_REQ_RSV,
    HS_REQ_ATYP, HS_IPV4, HS_DLEN, HS_NAME, HS_PORT_HI, HS_PORT_LO, HS_DONE, HS_ERROR
  } hs_phase_e;

  hs_phase_e   phase_q  = HS_GREET_VER;
  logic [7:0]  remain_q = '0;
  logic [1:0]  atyp_q   = '0;
  logic [31:0] addr_q   = '0;
  logic [15:0] port_q   = '0;

  result_t     owed_results_q[$];
  int unsigned errors = 0;

  task automatic note_error(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic clear_handshake();
    phase_q  = HS_GREET_VER;
    remain_q = '0;
    atyp_q   = '0;
    addr_q   = '0;
    port_q   = '0;
  endtask

  task automatic owe(input logic [1:0] kind, input logic [7:0] tx, input logic [2:0] oc,
                     input logic [1:0] at, input logic [31:0] addr, input logic [15:0] port);
    result_t r;
    r              = '0;
    r.kind         = kind;
    r.tx_byte      = tx;
    r.outcome      = oc;
    r.address_type = at;
    r.ipv4_address = addr;
    r.dest_port    = port;
    owed_results_q.push_back(r);
  endtask

  task automatic owe_tx(input logic [7:0] b);
    owe(KIND_TX, b, OC_ACCEPTED, 2'd0, 32'd0, 16'd0);
  endtask

  task automatic reject(input logic [2:0] oc, input bit with_reply);
    if (with_reply) begin
      owe_tx(SOCKS_VER);
      owe_tx(REP_FAIL);
    end
    owe(KIND_REPORT, 8'h00, oc, 2'd0, 32'd0, 16'd0);
    phase_q = HS_ERROR;
  endtask

  // Step the handshake by one client byte and queue what it owes
  task automatic advance_handshake(input logic cmd, input logic [7:0] b);
    int unsigned owed_at_entry;
    result_t     tail;
    owed_at_entry = owed_results_q.size();
    if (cmd) begin
      clear_handshake();
      return;
    end
    case (phase_q)
      HS_GREET_VER: begin
        if (b != SOCKS_VER) reject(OC_BAD_GREET, 1'b0);
        else phase_q = HS_GREET_CNT;
      end
      HS_GREET_CNT: begin
        remain_q = b;
        if (b == 8'd0) begin
          owe_tx(SOCKS_VER);
          owe_tx(REP_OK);
          phase_q = HS_REQ_VER;
        end else begin
          phase_q = HS_METHODS;
        end
      end
      HS_METHODS: begin
        remain_q = remain_q - 8'd1;
        if (remain_q == 8'd0) begin
          owe_tx(SOCKS_VER);
          owe_tx(REP_OK);
          phase_q = HS_REQ_VER;
        end
      end
      HS_REQ_VER: begin
        if (b != SOCKS_VER) reject(OC_BAD_REQ_VER, 1'b1);
        else phase_q = HS_REQ_CMD;
      end
      HS_REQ_CMD: begin
        if (b != CMD_CONNECT) reject(OC_BAD_CMD, 1'b1);
        else phase_q = HS_REQ_RSV;
      end
      HS_REQ_RSV: begin
        if (b != RSV_BYTE) reject(OC_BAD_RSV, 1'b1);
        else phase_q = HS_REQ_ATYP;
      end
      HS_REQ_ATYP: begin
        if (b == ATYP_IPV4 || b == ATYP_DOMAIN) begin
          atyp_q = b[1:0];
          addr_q = '0;
          owe_tx(SOCKS_VER);
          owe_tx(REP_OK);
          owe_tx(RSV_BYTE);
          owe_tx(b);
          if (b == ATYP_IPV4) begin
            remain_q = IPV4_LEN;
            phase_q  = HS_IPV4;
          end else begin
            phase_q = HS_DLEN;
          end
        end else begin
          reject(OC_BAD_ATYP, 1'b1);
        end
      end
      HS_IPV4: begin
        owe_tx(b);
        addr_q   = {addr_q[23:0], b};
        remain_q = remain_q - 8'd1;
        if (remain_q == 8'd0) phase_q = HS_PORT_HI;
      end
      HS_DLEN: begin
        owe_tx(b);
        remain_q = b;
        phase_q  = (b == 8'd0) ? HS_PORT_HI : HS_NAME;
      end
      HS_NAME: begin
        owe_tx(b);
        owe(KIND_NAME, b, OC_ACCEPTED, 2'd0, 32'd0, 16'd0);
        remain_q = remain_q - 8'd1;
        if (remain_q == 8'd0) phase_q = HS_PORT_HI;
      end
      HS_PORT_HI: begin
        owe_tx(b);
        port_q  = {b, 8'h00};
        phase_q = HS_PORT_LO;
      end
      HS_PORT_LO: begin
        owe_tx(b);
        port_q = {port_q[15:8], b};
        owe(KIND_REPORT, 8'h00, OC_ACCEPTED, atyp_q,
            (atyp_q == ATYP_IPV4[1:0]) ? addr_q : 32'd0, port_q);
        phase_q = HS_DONE;
      end
      default: ;
    endcase
    if (owed_results_q.size() > owed_at_entry) begin
      tail      = owed_results_q.pop_back();
      tail.last = 1'b1;
      owed_results_q.push_back(tail);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (owed_results_q.size() == 0) begin
      note_error($sformatf("result with nothing owed: kind %0d, byte %02h",
                           kind_i, tx_byte_i));
      return;
    end
    want = owed_results_q.pop_front();
    if (kind_i !== want.kind)
      note_error($sformatf("kind %0d, expected %0d", kind_i, want.kind));
    if (tx_byte_i !== want.tx_byte)
      note_error($sformatf("tx_byte %02h, expected %02h", tx_byte_i, want.tx_byte));
    if (outcome_i !== want.outcome)
      note_error($sformatf("outcome %0d, expected %0d", outcome_i, want.outcome));
    if (address_type_i !== want.address_type)
      note_error($sformatf("address_type %0d, expected %0d",
                           address_type_i, want.address_type));
    if (ipv4_address_i !== want.ipv4_address)
      note_error($sformatf("ipv4_address %08h, expected %08h",
                           ipv4_address_i, want.ipv4_address));
    if (dest_port_i !== want.dest_port)
      note_error($sformatf("dest_port %04h, expected %04h", dest_port_i, want.dest_port));
    if (last_i !== want.last)
      note_error($sformatf("last %0b, expected %0b", last_i, want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_handshake();
      owed_results_q.delete();
      pending_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) advance_handshake(cmd_i, rx_byte_i);
      pending_count_o <= owed_results_q.size();
    end
    error_count_o <= errors;
  end

endmodule

### sim/socks5_connect_handshake_tb.sv
`timescale 1ns / 100ps
// Testbench top for the SOCKS5 handshake: clock, reset, client byte stimulus and verdict.
module socks5_connect_handshake_tb;
  import s5h_pkg::*;

  // Stop making sessions once this many client transactions have gone in
  localparam int unsigned ITEM_TARGET    = 370;
  // Longest run of cycles with no transaction on either channel
  localparam int unsigned WATCHDOG_LIMIT = 500;
  // Cycles to hold on after the last owed result, to catch stray extras
  localparam int unsigned DRAIN_CYCLES   = 20;

  localparam logic CLIENT_BYTE = 1'b0;
  localparam logic NEW_CONN    = 1'b1;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic        cmd       = 1'b0;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic [2:0]  outcome;
  logic [1:0]  address_type;
  logic [31:0] ipv4_address;
  logic [15:0] dest_port;
  logic        last;

  int unsigned errors;
  int unsigned pending;
  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;
  // While set, both sides run flat out with no idling
  bit          calm         = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  socks5_connect_handshake dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cmd_i          (cmd),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .tx_byte_o      (tx_byte),
    .outcome_o      (outcome),
    .address_type_o (address_type),
    .ipv4_address_o (ipv4_address),
    .dest_port_o    (dest_port),
    .last_o         (last)
  );

  s5h_handshake_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .cmd_i           (cmd),
    .rx_byte_i       (rx_byte),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .kind_i          (kind),
    .tx_byte_i       (tx_byte),
    .outcome_i       (outcome),
    .address_type_i  (address_type),
    .ipv4_address_i  (ipv4_address),
    .dest_port_i     (dest_port),
    .last_i          (last),
    .error_count_o   (errors),
    .pending_count_o (pending)
  );

  // Offer one transaction on the client channel and hold it until taken.
  // Idle for a drawn number of cycles first; with no idle, keep valid high
  // so back-to-back transactions never see valid dip within a time step.
  task automatic send_byte(input logic c, input logic [7:0] b);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    rx_byte  <= b;
    // Inputs are sampled before the edge updates, so in_stall is the value
    // the block saw at this edge
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Build one client connection: mostly a well-formed greeting and CONNECT
  // request with random content, sometimes with a damaged byte, cut short,
  // or trailed by noise that the block should ignore.
  task automatic run_session();
    logic [7:0]  conn_q[$];
    logic [7:0]  atyp_byte;
    int unsigned n_methods;
    int unsigned name_len;
    int unsigned spot;
    int unsigned keep;
    calm = ($urandom_range(0, 4) == 0);
    // Usually open a fresh connection; otherwise carry on from whatever
    // state the last session left behind
    if ($urandom_range(0, 7) != 0) send_byte(NEW_CONN, 8'($urandom_range(0, 255)));

    // Greeting: a rare full-size method list, otherwise a short one
    n_methods = ($urandom_range(0, 39) == 0) ? 255 : $urandom_range(0, 3);
    conn_q.push_back(SOCKS_VER);
    conn_q.push_back(8'(n_methods));
    repeat (n_methods) conn_q.push_back(8'($urandom_range(0, 255)));

    // Request header
    conn_q.push_back(SOCKS_VER);
    conn_q.push_back(CMD_CONNECT);
    conn_q.push_back(RSV_BYTE);
    case ($urandom_range(0, 9))
      0:          atyp_byte = 8'($urandom_range(0, 255));
      1, 2, 3, 4: atyp_byte = ATYP_IPV4;
      default:    atyp_byte = ATYP_DOMAIN;
    endcase
    conn_q.push_back(atyp_byte);

    // Destination and port
    if (atyp_byte == ATYP_IPV4) begin
      repeat (4) conn_q.push_back(8'($urandom_range(0, 255)));
    end else if (atyp_byte == ATYP_DOMAIN) begin
      name_len = ($urandom_range(0, 39) == 0) ? 255 : $urandom_range(0, 6);
      conn_q.push_back(8'(name_len));
      repeat (name_len) conn_q.push_back(8'($urandom_range(0, 255)));
    end
    repeat (2) conn_q.push_back(8'($urandom_range(0, 255)));

    // Damage one byte, aiming mostly at the header checks
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 5))
        0:       spot = 0;
        1:       spot = 1;
        2:       spot = 2 + n_methods;
        3:       spot = 3 + n_methods;
        4:       spot = 4 + n_methods;
        default: spot = $urandom_range(0, conn_q.size() - 1);
      endcase
      conn_q[spot] = conn_q[spot] ^ 8'($urandom_range(1, 255));
    end

    // Cut the connection short
    if ($urandom_range(0, 7) == 0) begin
      keep = $urandom_range(1, conn_q.size());
      while (conn_q.size() > keep) void'(conn_q.pop_back());
    end

    // Trailing bytes after the handshake has finished or failed
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3)) conn_q.push_back(8'($urandom_range(0, 255)));

    // Stop at the item budget, even part way through a long session
    foreach (conn_q[i])
      if (items_sent < ITEM_TARGET) send_byte(CLIENT_BYTE, conn_q[i]);
  endtask

  // Result sink: stall for a drawn number of cycles before each result,
  // then take it. Stall is only ever changed here.
  initial begin
    int unsigned hold;
    wait (rst_n);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 13);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wrong greeting version: report only, no reply bytes; then a byte that
    // the block must drop while in the error state
    send_byte(CLIENT_BYTE, 8'h04);
    send_byte(CLIENT_BYTE, SOCKS_VER);

    // Zero methods, so the 05 00 reply follows the count byte at once;
    // IPv4 with extreme address and port bytes, then a dropped extra byte
    send_byte(NEW_CONN, 8'h00);
    send_byte(CLIENT_BYTE, SOCKS_VER);
    send_byte(CLIENT_BYTE, 8'h00);
    send_byte(CLIENT_BYTE, SOCKS_VER);
    send_byte(CLIENT_BYTE, CMD_CONNECT);
    send_byte(CLIENT_BYTE, RSV_BYTE);
    send_byte(CLIENT_BYTE, ATYP_IPV4);
    send_byte(CLIENT_BYTE, 8'hFF);
    send_byte(CLIENT_BYTE, 8'h00);
    send_byte(CLIENT_BYTE, 8'h80);
    send_byte(CLIENT_BYTE, 8'h7F);
    send_byte(CLIENT_BYTE, 8'hFF);
    send_byte(CLIENT_BYTE, 8'hFF);
    send_byte(CLIENT_BYTE, 8'h5A);

    // One method; domain of length zero, so the port follows straight away
    send_byte(NEW_CONN, 8'hFF);
    send_byte(CLIENT_BYTE, SOCKS_VER);
    send_byte(CLIENT_BYTE, 8'h01);
    send_byte(CLIENT_BYTE, 8'h00);
    send_byte(CLIENT_BYTE, SOCKS_VER);
    send_byte(CLIENT_BYTE, CMD_CONNECT);
    send_byte(CLIENT_BYTE, RSV_BYTE);
    send_byte(CLIENT_BYTE, ATYP_DOMAIN);
    send_byte(CLIENT_BYTE, 8'h00);
    send_byte(CLIENT_BYTE, 8'h00);
    send_byte(CLIENT_BYTE, 8'h00);

    while (items_sent < ITEM_TARGET) run_session();
    in_valid <= 1'b0;

    // Advance one edge so the count reflects the last transaction, then wait
    // for every owed result and drain a little longer for stray ones
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

### sim.f
design/s5h_pkg.sv
design/s5h_parse.sv
design/s5h_fifo.sv
design/socks5_connect_handshake.sv
design/s5h_checker.sv
sim/s5h_handshake_checker.sv
sim/socks5_connect_handshake_tb.sv
